// ===== rtl/sdl_pkg.sv =====
// ----------------------------------------------------------------------------
// sdl_pkg: shared types for the sorted descending list
// Opcodes, field widths and the link carried between neighboring cells.
// ----------------------------------------------------------------------------
package sdl_pkg;

  localparam int ValueW = 32;
  localparam int PosW   = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PROBE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } sdl_op_e;

  // handed from cell i to cell i+1 every cycle
  typedef struct packed {
    logic signed [ValueW-1:0] entry;  // stored value of the left cell
    logic                     keep;   // left cell holds its value on insert
  } sdl_link_t;

endpackage

// ===== rtl/sdl_intf.sv =====
// ----------------------------------------------------------------------------
// sdl_intf: channel interfaces of the sorted descending list
// Request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdl_in_if;
  logic                                valid;
  logic                                ready;
  sdl_pkg::sdl_op_e                    opcode;
  logic signed [sdl_pkg::ValueW-1:0]   value;
  logic        [sdl_pkg::PosW-1:0]     probe_position;
  logic                                last_probe;

  modport source (output valid, opcode, value, probe_position, last_probe,
                  input ready);
  modport sink   (input valid, opcode, value, probe_position, last_probe,
                  output ready);
endinterface

interface sdl_out_if #(
  parameter int CntW = 5
);
  logic                           valid;
  logic                           ready;
  logic [CntW-1:0]                length;
  logic                           dropped;
  logic                           answer_valid;
  logic                           answer_found;
  logic [sdl_pkg::PosW-1:0]       answer_index;

  modport source (output valid, length, dropped, answer_valid, answer_found,
                  answer_index, input ready);
  modport sink   (input valid, length, dropped, answer_valid, answer_found,
                  answer_index, output ready);
endinterface

// ===== rtl/sdl_cell.sv =====
// ----------------------------------------------------------------------------
// sdl_cell: one slot of the sorted list
// Holds one entry; on insert it keeps, takes the new value or takes its
// left neighbor's entry.
// ----------------------------------------------------------------------------
module sdl_cell (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic                              occupied_i,
  input  logic signed [sdl_pkg::ValueW-1:0] value_i,
  input  sdl_pkg::sdl_link_t                link_i,
  output sdl_pkg::sdl_link_t                link_o,
  output logic                              gt_o
);
  import sdl_pkg::*;

  logic signed [ValueW-1:0] entry_q;
  logic                     gt;
  logic                     keep;

  assign gt   = entry_q > value_i;
  assign keep = occupied_i & gt;

  // left neighbor keeping means the new value lands here
  always_ff @(posedge clk_i) begin
    if (load_i && !keep) begin
      entry_q <= link_i.keep ? value_i : link_i.entry;
    end
  end

  assign link_o.entry = entry_q;
  assign link_o.keep  = keep;
  assign gt_o         = gt;

endmodule

// ===== rtl/sorted_descending_list_with_probe_core.sv =====
// ----------------------------------------------------------------------------
// sorted_descending_list_with_probe_core: sorted list with probe runs
// Chain of DEPTH cells holding signed values in descending order.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one word per item: opcode (insert, probe, clear), value,
//         probe_position and last_probe.
//   out_o returns exactly one word per accepted item, in order: the length
//         after the item, dropped on an insert into a full list, and on the
//         last probe of a run whether some probe fell below every stored
//         value and the position of the first one.
//   out_o.valid is registered and rises in the cycle after acceptance. The list takes one
//   item per cycle while the receiver takes the results: every cell compares its entry
//   with the incoming value in parallel and shifts right in the same edge, so the list
//   is up to date for the next item.
//   The output register accepts a new item in the cycle its word is taken,
//   so a receiver that always takes sees no bubbles; when it stalls,
//   in_i.ready drops and the result word holds.
//   Reset empties the list and clears the open probe run; cell contents
//   are not cleared, entries beyond the length are never consulted.
// ----------------------------------------------------------------------------
module sorted_descending_list_with_probe_core #(
  parameter int DEPTH = 16
) (
  input logic     clk_i,
  input logic     rst_ni,
  sdl_in_if.sink  in_i,
  sdl_out_if.source out_o
);
  import sdl_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            hit_seen_q, hit_seen_d;
  logic [PosW-1:0] hit_pos_q, hit_pos_d;

  logic            out_valid_q;
  logic [CntW-1:0] len_q;
  logic            dropped_q, dropped_d;
  logic            ans_valid_q, ans_valid_d;
  logic            ans_found_q, ans_found_d;
  logic [PosW-1:0] ans_index_q, ans_index_d;

  logic accept;
  logic do_insert;
  logic full;
  logic below;

  sdl_link_t       link [DEPTH+1];
  logic [DEPTH-1:0] gt_vec;
  logic [DEPTH-1:0] last_vec;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign do_insert  = accept && (in_i.opcode == OP_INSERT);

  // head of the chain: a keeping "cell -1" makes cell 0 take the value
  assign link[0].entry = '0;
  assign link[0].keep  = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sdl_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (do_insert),
      .occupied_i (count_q > CntW'(i)),
      .value_i    (in_i.value),
      .link_i     (link[i]),
      .link_o     (link[i+1]),
      .gt_o       (gt_vec[i])
    );
    // marks the smallest stored entry
    assign last_vec[i] = (count_q == CntW'(i + 1));
  end

  assign full  = (count_q == CntW'(DEPTH));
  // strictly below the smallest entry, or list empty
  assign below = (count_q == '0) || |(last_vec & gt_vec);

  always_comb begin
    count_d     = count_q;
    hit_seen_d  = hit_seen_q;
    hit_pos_d   = hit_pos_q;
    dropped_d   = 1'b0;
    ans_valid_d = 1'b0;
    ans_found_d = 1'b0;
    ans_index_d = '0;
    unique case (in_i.opcode)
      OP_INSERT: begin
        // full list: the smallest value leaves, length stays
        dropped_d = full;
        if (!full) begin
          count_d = count_q + CntW'(1);
        end
      end
      OP_PROBE: begin
        if (below && !hit_seen_q) begin
          hit_seen_d = 1'b1;
          hit_pos_d  = in_i.probe_position;
        end
        if (in_i.last_probe) begin
          ans_valid_d = 1'b1;
          ans_found_d = hit_seen_d;
          ans_index_d = hit_seen_d ? hit_pos_d : '0;
          hit_seen_d  = 1'b0;
          hit_pos_d   = '0;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      hit_seen_q  <= 1'b0;
      hit_pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q    <= count_d;
        hit_seen_q <= hit_seen_d;
        hit_pos_q  <= hit_pos_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_q       <= count_d;
      dropped_q   <= dropped_d;
      ans_valid_q <= ans_valid_d;
      ans_found_q <= ans_found_d;
      ans_index_q <= ans_index_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.length       = len_q;
  assign out_o.dropped      = dropped_q;
  assign out_o.answer_valid = ans_valid_q;
  assign out_o.answer_found = ans_found_q;
  assign out_o.answer_index = ans_index_q;

endmodule

// ===== rtl/sdl_checker.sv =====
// ----------------------------------------------------------------------------
// sdl_checker: port-level checks for the sorted descending list
// Watches the channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module sdl_checker #(
  parameter int DEPTH = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [$clog2(DEPTH+1)-1:0]      length_i,
  input logic                            dropped_i,
  input logic                            answer_valid_i,
  input logic                            answer_found_i,
  input logic [sdl_pkg::PosW-1:0]        answer_index_i
);
  import sdl_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(length_i)
      && $stable(answer_index_i))
    else $error("result word changed while stalled");

  // every accepted word yields a result in the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("missing result after accepted word");

  // a drop only happens on a full list
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && dropped_i |-> length_i == CntW'(DEPTH) && !answer_valid_i)
    else $error("drop reported with list not full");

  // answer fields are zero outside a run's end, index zero without a hit
  a_answer_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !(answer_valid_i && answer_found_i)
      |-> answer_index_i == '0 && (answer_valid_i || !answer_found_i))
    else $error("answer fields set without a hit");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> length_i <= CntW'(DEPTH))
    else $error("length above depth");

endmodule

bind sorted_descending_list_with_probe_core sdl_checker #(
  .DEPTH(DEPTH)
) u_sdl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .length_i       (out_o.length),
  .dropped_i      (out_o.dropped),
  .answer_valid_i (out_o.answer_valid),
  .answer_found_i (out_o.answer_found),
  .answer_index_i (out_o.answer_index)
);

// ===== bench/sorted_descending_list_with_probe_core_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_descending_list_with_probe_core_tb: self-checking bench for the list
// Drives insert, probe, clear and no-op words through the request channel,
// predicts every result word from a shadow copy of the sorted list, and
// compares each returned word field by field. A directed table comes first,
// then randomized inserts and probe runs, with random idling on both sides.
// ----------------------------------------------------------------------------
module sorted_descending_list_with_probe_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdl_pkg::*;

  localparam int          DEPTH     = 16;
  localparam int          CNT_W     = 5;
  localparam int          RAND_N    = 1250;
  localparam int          LIMIT     = 500_000;  // cycles before the watchdog fires
  localparam int          HOLD_LEN  = 400;      // long receiver hold-off
  localparam logic [31:0] MAX_V     = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_V     = 32'h8000_0000;

  // one result word, as the block returns it
  typedef struct packed {
    logic [CNT_W-1:0] length;
    logic             dropped;
    logic             ans_valid;
    logic             ans_found;
    logic [PosW-1:0]  ans_index;
  } list_result_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    sdl_op_e         op;
    logic [31:0]     value;
    logic [PosW-1:0] pos;
    logic            last;
    logic            typed;
    list_result_t    want;
  } stim_row_t;

  localparam list_result_t NO_RES = '0;
  localparam int           DIR_N  = 25;

  // Directed words. Comments note what each word exercises.
  localparam stim_row_t DIR_TBL [DIR_N] = '{
    // probe on an empty store: counts as below all, reported at once
    '{OP_PROBE,  32'd0,       8'h5A, 1'b1, 1'b1, '{5'd0, 1'b0, 1'b1, 1'b1, 8'h5A}},
    '{OP_INSERT, MAX_V,       8'h00, 1'b0, 1'b1, '{5'd1, 1'b0, 1'b0, 1'b0, 8'h00}},
    '{OP_INSERT, 32'd0,       8'h00, 1'b0, 1'b1, '{5'd2, 1'b0, 1'b0, 1'b0, 8'h00}},
    // equal value goes ahead of the existing 0
    '{OP_INSERT, 32'd0,       8'hFF, 1'b1, 1'b1, '{5'd3, 1'b0, 1'b0, 1'b0, 8'h00}},
    // -1 < 0: opens a hit at position 0, not last so no answer yet
    '{OP_PROBE,  32'hFFFF_FFFF, 8'h00, 1'b0, 1'b1, '{5'd3, 1'b0, 1'b0, 1'b0, 8'h00}},
    // insert in the middle of a run
    '{OP_INSERT, -32'sd50,    8'h00, 1'b0, 1'b1, '{5'd4, 1'b0, 1'b0, 1'b0, 8'h00}},
    // closes the run: hit carried from the earlier probe
    '{OP_PROBE,  32'd7,       8'hFF, 1'b1, 1'b0, NO_RES},
    // unused opcode with every other field set
    '{OP_NOP,    32'hFFFF_FFFF, 8'hAA, 1'b1, 1'b1, '{5'd4, 1'b0, 1'b0, 1'b0, 8'h00}},
    // equal to the smallest entry is not below: last probe, no hit
    '{OP_PROBE,  -32'sd50,    8'h03, 1'b1, 1'b1, '{5'd4, 1'b0, 1'b1, 1'b0, 8'h00}},
    // fill up to DEPTH
    '{OP_INSERT, 32'd100,     8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, -32'sd100,   8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, 32'd55,      8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, -32'sd7,     8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, 32'd1234567, 8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, -32'sd1234567, 8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, 32'd3,       8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, 32'd3,       8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, -32'sd2,     8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, 32'd40000,   8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, -32'sd40000, 8'h00, 1'b0, 1'b0, NO_RES},
    '{OP_INSERT, 32'd17,      8'h00, 1'b0, 1'b1, '{5'd16, 1'b0, 1'b0, 1'b0, 8'h00}},
    // full, new value strictly smallest: it is the one pushed out
    '{OP_INSERT, MIN_V,       8'h00, 1'b0, 1'b1, '{5'd16, 1'b1, 1'b0, 1'b0, 8'h00}},
    // full, largest value: old smallest entry is pushed out
    '{OP_INSERT, MAX_V,       8'h00, 1'b0, 1'b1, '{5'd16, 1'b1, 1'b0, 1'b0, 8'h00}},
    // most negative probe is below everything left
    '{OP_PROBE,  MIN_V,       8'h09, 1'b1, 1'b0, NO_RES},
    '{OP_CLEAR,  32'd0,       8'h00, 1'b0, 1'b1, '{5'd0, 1'b0, 1'b0, 1'b0, 8'h00}}
  };

  logic clk_i;
  logic rst_ni;

  sdl_in_if                  in_if ();
  sdl_out_if #(.CntW(CNT_W)) out_if ();

  sorted_descending_list_with_probe_core #(
    .DEPTH (DEPTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // --------------------------------------------------------------------------
  // Shadow list and the words still owed by the block
  // --------------------------------------------------------------------------
  logic signed [31:0] shadow_list [DEPTH];
  int                 shadow_fill = 0;
  logic               run_hit     = 1'b0;
  logic [PosW-1:0]    run_hit_pos = '0;

  list_result_t owed_words [$];

  int  errors      = 0;
  int  cycles      = 0;
  int  words_sent  = 0;
  int  words_back  = 0;
  int  n_insert    = 0;
  int  n_probe     = 0;
  int  n_clear     = 0;
  int  n_nop       = 0;
  int  n_runs      = 0;
  int  n_dropped   = 0;
  int  n_found     = 0;

  bit  burst_mode     = 1'b0;   // sender: no gaps while set
  bit  long_hold_due  = 1'b0;   // sender asks the receiver for one long stall
  bit  long_hold_done = 1'b0;

  // Apply one word to the shadow list, return the word the block should send.
  function automatic list_result_t list_step(sdl_op_e op, logic [31:0] raw,
                                             logic [PosW-1:0] pos, logic last);
    list_result_t       res;
    logic signed [31:0] v;
    int                 slot;
    int                 k;
    logic               below;
    res = '0;
    v   = $signed(raw);
    case (op)
      OP_INSERT: begin
        slot = 0;
        while (slot < shadow_fill && v < shadow_list[slot]) slot++;
        if (shadow_fill == DEPTH) begin
          res.dropped = 1'b1;
          // smallest entry leaves; a new value smaller than all leaves the list as it is
          if (slot < DEPTH) shadow_fill = DEPTH - 1;
        end
        if (shadow_fill < DEPTH) begin
          for (k = shadow_fill; k > slot; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[slot] = v;
          shadow_fill++;
        end
      end
      OP_PROBE: begin
        below = (shadow_fill == 0) || (v < shadow_list[shadow_fill-1]);
        if (below && !run_hit) begin
          run_hit     = 1'b1;
          run_hit_pos = pos;
        end
        if (last) begin
          res.ans_valid = 1'b1;
          res.ans_found = run_hit;
          res.ans_index = run_hit ? run_hit_pos : '0;
          run_hit       = 1'b0;
          run_hit_pos   = '0;
        end
      end
      OP_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    res.length = shadow_fill[CNT_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // values cluster near zero so that equal and nearby entries are common
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 40) - 20;
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0:       return MAX_V;
        1:       return MIN_V;
        2:       return MAX_V - 1;
        default: return MIN_V + 1;
      endcase
    end
    return $urandom();
  endfunction

  // probe values aimed at the smallest entry: just below it, equal, or random
  function automatic logic [31:0] pick_probe();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (shadow_fill > 0 && r < 25) return shadow_list[shadow_fill-1] - 1;
    if (shadow_fill > 0 && r < 35) return shadow_list[shadow_fill-1];
    return pick_value();
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one word, hold it until taken, then log what the block owes for it.
  task automatic send_word(input sdl_op_e op, input logic [31:0] v,
                           input logic [PosW-1:0] pos, input logic last,
                           input logic typed = 1'b0,
                           input list_result_t want = '0);
    list_result_t pred;
    int           gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.opcode         <= op;
    in_if.value          <= v;
    in_if.probe_position <= pos;
    in_if.last_probe     <= last;
    do @(posedge clk_i); while (!in_if.ready);
    pred = list_step(op, v, pos, last);
    owed_words.push_back(typed ? want : pred);
    words_sent++;
    case (op)
      OP_INSERT: n_insert++;
      OP_PROBE: begin
        n_probe++;
        if (last) n_runs++;
      end
      OP_CLEAR: n_clear++;
      default:  n_nop++;
    endcase
  endtask

  // stop offering and wait until every owed word has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
  endtask

  // A probe run: positions usually count up from zero and the final one
  // carries last. Some runs are broken: scattered positions, no last marker,
  // or an insert or clear slipped in between probes.
  task automatic send_probe_run();
    int              run_len;
    int              k;
    logic [PosW-1:0] base;
    logic [PosW-1:0] pos;
    bit              scatter;
    bit              no_last;
    run_len = $urandom_range(1, 8);
    base    = ($urandom_range(0, 4) == 0) ? PosW'($urandom_range(0, 255)) : '0;
    scatter = ($urandom_range(0, 9) == 0);
    no_last = ($urandom_range(0, 9) == 0);
    for (k = 0; k < run_len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 3) == 0)
          send_word(OP_CLEAR, $urandom(), PosW'($urandom()), 1'($urandom()));
        else
          send_word(OP_INSERT, pick_value(), PosW'($urandom()), 1'($urandom()));
      end
      pos = scatter ? PosW'($urandom_range(0, 255)) : base + PosW'(k);
      send_word(OP_PROBE, pick_probe(), pos, (k == run_len - 1) && !no_last);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off, field-by-field checks
  // --------------------------------------------------------------------------
  task automatic check_word();
    list_result_t want;
    words_back++;
    if (out_if.dropped)      n_dropped++;
    if (out_if.answer_found) n_found++;
    if (owed_words.size() == 0) begin
      $error("result word with nothing expected (length %0d)", out_if.length);
      errors++;
      return;
    end
    want = owed_words.pop_front();
    if (out_if.length !== want.length) begin
      $error("length: expected %0d, got %0d", want.length, out_if.length);
      errors++;
    end
    if (out_if.dropped !== want.dropped) begin
      $error("dropped: expected %0b, got %0b", want.dropped, out_if.dropped);
      errors++;
    end
    if (out_if.answer_valid !== want.ans_valid) begin
      $error("answer_valid: expected %0b, got %0b", want.ans_valid, out_if.answer_valid);
      errors++;
    end
    if (out_if.answer_found !== want.ans_found) begin
      $error("answer_found: expected %0b, got %0b", want.ans_found, out_if.answer_found);
      errors++;
    end
    if (out_if.answer_index !== want.ans_index) begin
      $error("answer_index: expected %0d, got %0d", want.ans_index, out_if.answer_index);
      errors++;
    end
  endtask

  initial begin
    int  stall_left;
    bit  rx_eager;
    stall_left = 0;
    rx_eager   = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) check_word();
      // the sender asked once for a long hold-off: the list backs up and
      // in_i.ready must drop while words keep being offered
      if (long_hold_due && !long_hold_done) begin
        stall_left     = HOLD_LEN;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!rx_eager && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
      if ($urandom_range(0, 299) == 0) rx_eager = !rx_eager;
    end
  end

  // --------------------------------------------------------------------------
  // Clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < LIMIT) @(posedge clk_i) cycles++;
    $display("Timeout after %0d cycles, %0d words still owed", cycles, owed_words.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          i;
    int unsigned pick;
    int          burst_len;
    bit          paused_once;
    paused_once = 1'b0;

    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.opcode         <= OP_NOP;
    in_if.value          <= '0;
    in_if.probe_position <= '0;
    in_if.last_probe     <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < DIR_N; i++) begin
      send_word(DIR_TBL[i].op, DIR_TBL[i].value, DIR_TBL[i].pos, DIR_TBL[i].last,
                DIR_TBL[i].typed, DIR_TBL[i].want);
    end
    drain_results();

    // random part: insert bursts keep the list near full, clears empty it
    while (words_sent < DIR_N + RAND_N) begin
      if (!long_hold_due && words_sent >= 400) long_hold_due = 1'b1;
      if (!paused_once && words_sent >= 800) begin
        paused_once = 1'b1;
        drain_results();
      end
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        burst_len = $urandom_range(1, 6);
        repeat (burst_len)
          send_word(OP_INSERT, pick_value(), PosW'($urandom()), 1'($urandom()));
      end else if (pick < 85) begin
        send_probe_run();
      end else if (pick < 90) begin
        send_word(OP_CLEAR, $urandom(), PosW'($urandom()), 1'($urandom()));
      end else if (pick < 95) begin
        send_word(OP_NOP, $urandom(), PosW'($urandom()), 1'($urandom()));
      end else begin
        // stray probe with arbitrary fields
        send_word(OP_PROBE, $urandom(), PosW'($urandom()), 1'($urandom()));
      end
    end

    drain_results();
    repeat (5) @(posedge clk_i);  // catch any stray word after the last one

    $display("Ran %0d words in %0d cycles: %0d inserts (%0d pushed out), %0d clears, %0d no-ops",
             words_sent, cycles, n_insert, n_dropped, n_clear, n_nop);
    $display("%0d probes closed %0d runs, %0d of them reporting a probe below the list",
             n_probe, n_runs, n_found);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
